// File: rtl/tlc_pkg.sv
// Shared constants, codes and types of the terminal line cooker.
package tlc_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int PTR_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int LEN_W      = 6;
    localparam int MAX_READ   = 32;
    localparam int IDX_W      = 3;

    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [2:0] KIND_ECHO    = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_EOF     = 3'd2;
    localparam logic [2:0] KIND_NONE    = 3'd3;
    localparam logic [2:0] KIND_REFUSED = 3'd4;

    localparam logic [IDX_W-1:0] CFG_RAW  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ECHO = 3'd1;
    localparam logic [IDX_W-1:0] CFG_N2R  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_IGN  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_R2N  = 3'd4;

    typedef struct packed {
        logic raw;
        logic echo;
        logic n2r;
        logic ign;
        logic r2n;
    } t_cfg;

    typedef struct packed {
        logic       refuse;
        logic       push;
        logic       pop;
        logic       set_ready;
        logic       set_eof;
        logic       echo;
        logic       erase_echo;
        logic [7:0] ch;
    } t_char_act;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHAR  = 6'b000010,
        S_EMIT  = 6'b000100,
        S_RDCHK = 6'b001000,
        S_RDADR = 6'b010000,
        S_RDDAT = 6'b100000
    } t_state;

endpackage

// File: rtl/tlc_ram.sv
// Line store: one write port, one registered read port.
module tlc_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [tlc_pkg::PTR_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic                      i_re,
    input  logic [tlc_pkg::PTR_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);

    logic [7:0] r_mem [tlc_pkg::LINE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tlc_decode.sv
// Character classifier: works out the edit action and echo for one arriving character.
module tlc_decode (
    input  logic [7:0]                i_char,
    input  tlc_pkg::t_cfg             i_cfg,
    input  logic [tlc_pkg::CNT_W-1:0] i_fill,
    input  logic                      i_line_ready,
    output tlc_pkg::t_char_act        o_act
);

    logic full;
    logic is_erase;

    assign full     = (i_fill == tlc_pkg::CNT_W'(tlc_pkg::LINE_DEPTH));
    assign is_erase = (i_char == tlc_pkg::CH_BS) || (i_char == tlc_pkg::CH_DEL);

    always_comb begin
        o_act    = '0;
        o_act.ch = i_char;
        if (i_line_ready || full) begin
            o_act.refuse = 1'b1;
        end else if (i_cfg.raw) begin
            o_act.push       = 1'b1;
            o_act.echo       = 1'b1;
            o_act.erase_echo = is_erase;
        end else begin
            case (i_char) inside
                tlc_pkg::CH_BS, tlc_pkg::CH_DEL: begin
                    if (i_fill != '0) begin
                        o_act.pop        = 1'b1;
                        o_act.echo       = i_cfg.echo;
                        o_act.erase_echo = 1'b1;
                    end
                end
                tlc_pkg::CH_NL: begin
                    o_act.ch        = i_cfg.n2r ? tlc_pkg::CH_CR : tlc_pkg::CH_NL;
                    o_act.push      = 1'b1;
                    o_act.set_ready = 1'b1;
                    o_act.echo      = i_cfg.echo;
                end
                tlc_pkg::CH_CR: begin
                    if (!i_cfg.ign) begin
                        o_act.ch        = i_cfg.r2n ? tlc_pkg::CH_NL : tlc_pkg::CH_CR;
                        o_act.push      = 1'b1;
                        o_act.set_ready = 1'b1;
                        o_act.echo      = i_cfg.echo;
                    end
                end
                tlc_pkg::CH_EOT: begin
                    o_act.set_eof   = 1'b1;
                    o_act.set_ready = 1'b1;
                    o_act.echo      = i_cfg.echo;
                end
                [tlc_pkg::CH_SPACE:tlc_pkg::CH_TILDE]: begin
                    o_act.push = 1'b1;
                    o_act.echo = i_cfg.echo;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/terminal_line_cooker.sv
// Terminal line cooker top level: sequencer, ring state, config and output register.
//
// Input channel (i_in_valid / o_in_stall) takes one item: a received character
// (i_op 0) or a read request (i_op 1, i_read_len characters at most, clamped to 32).
// Output channel (o_out_valid / i_out_stall) returns the results of that item,
// o_last marking the final one. Every item gives at least one result except a
// dropped character or an accepted character with echo off.
// Only one item is worked on at a time; o_in_stall is high until all of its
// results have been loaded into the output register.
// Character: the transfer, a decode step (S_CHAR), then one result per cycle
// from S_EMIT while the output is not stalled (0, 1 or 3 results).
// Read: a check step (S_RDCHK), then each delivered byte runs the line store
// loop (address state S_RDADR, registered read data state S_RDDAT) before the
// next byte starts; an end-of-file or nothing-ready answer comes from S_EMIT.
// Reset (synchronous, active low) empties the line, clears line-ready and
// end-of-file, and loads the register defaults (echo and return-to-newline on).
// The store contents are not cleared; no clearing pass is needed.
// A stall on the output holds the output register; the sequencer waits.
module terminal_line_cooker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic [7:0]                        i_char_in,
    input  logic [tlc_pkg::LEN_W-1:0]         i_read_len,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_kind,
    output logic [7:0]                        o_value,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [tlc_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic                              i_cfg_data
);

    tlc_pkg::t_state             r_state, n_state;
    tlc_pkg::t_cfg               r_cfg;
    logic [tlc_pkg::PTR_W-1:0]   r_head, n_head;
    logic [tlc_pkg::CNT_W-1:0]   r_fill, n_fill;
    logic                        r_ready, n_ready;
    logic                        r_eof, n_eof;
    logic [7:0]                  r_char;
    logic [tlc_pkg::LEN_W-1:0]   r_len;
    logic [tlc_pkg::LEN_W-1:0]   r_n, n_n;
    logic [1:0]                  r_cnt, n_cnt;
    logic [2:0]                  r_ekind, n_ekind;
    logic [7:0]                  r_evalue, n_evalue;
    logic                        r_erase, n_erase;
    logic                        r_out_valid;
    logic [2:0]                  r_kind;
    logic [7:0]                  r_value;
    logic                        r_last;

    tlc_pkg::t_char_act          act;
    logic                        in_xfer;
    logic                        slot_free;
    logic                        full;
    logic                        rd_last;
    logic [tlc_pkg::CNT_W:0]     w_sum;
    logic [tlc_pkg::PTR_W-1:0]   w_addr;
    logic                        ram_we;
    logic                        ram_re;
    logic [7:0]                  ram_rdata;
    logic                        emit_valid;
    logic [2:0]                  emit_kind;
    logic [7:0]                  emit_value;
    logic                        emit_last;
    logic [tlc_pkg::LEN_W-1:0]   len_clamped;

    assign o_in_stall = (r_state != tlc_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign full       = (r_fill == tlc_pkg::CNT_W'(tlc_pkg::LINE_DEPTH));
    assign rd_last    = (r_fill == tlc_pkg::CNT_W'(1)) || ((r_n + 1'b1) == r_len);
    assign len_clamped = (i_read_len > tlc_pkg::LEN_W'(tlc_pkg::MAX_READ)) ?
                         tlc_pkg::LEN_W'(tlc_pkg::MAX_READ) : i_read_len;

    // write position: head + fill, wrapped once
    assign w_sum  = (tlc_pkg::CNT_W+1)'(r_head) + (tlc_pkg::CNT_W+1)'(r_fill);
    assign w_addr = (w_sum >= (tlc_pkg::CNT_W+1)'(tlc_pkg::LINE_DEPTH)) ?
                    tlc_pkg::PTR_W'(w_sum - (tlc_pkg::CNT_W+1)'(tlc_pkg::LINE_DEPTH)) :
                    tlc_pkg::PTR_W'(w_sum);

    tlc_decode u_decode (
        .i_char       (r_char),
        .i_cfg        (r_cfg),
        .i_fill       (r_fill),
        .i_line_ready (r_ready),
        .o_act        (act)
    );

    tlc_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (w_addr),
        .i_wdata (act.ch),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_ready    = r_ready;
        n_eof      = r_eof;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_ekind    = r_ekind;
        n_evalue   = r_evalue;
        n_erase    = r_erase;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        emit_valid = 1'b0;
        emit_kind  = tlc_pkg::KIND_ECHO;
        emit_value = '0;
        emit_last  = 1'b0;
        case (r_state)
            tlc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = i_op ? tlc_pkg::S_RDCHK : tlc_pkg::S_CHAR;
                end
            end
            tlc_pkg::S_CHAR: begin
                ram_we = act.push;
                if (act.push) begin
                    n_fill = r_fill + 1'b1;
                end else if (act.pop) begin
                    n_fill = r_fill - 1'b1;
                end
                if (act.set_ready) begin
                    n_ready = 1'b1;
                end
                if (act.set_eof) begin
                    n_eof = 1'b1;
                end
                n_ekind  = act.refuse ? tlc_pkg::KIND_REFUSED : tlc_pkg::KIND_ECHO;
                n_evalue = act.ch;
                n_erase  = act.erase_echo;
                if (act.refuse) begin
                    n_cnt   = 2'd1;
                    n_state = tlc_pkg::S_EMIT;
                end else if (act.echo) begin
                    n_cnt   = act.erase_echo ? 2'd3 : 2'd1;
                    n_state = tlc_pkg::S_EMIT;
                end else begin
                    n_state = tlc_pkg::S_IDLE;
                end
            end
            tlc_pkg::S_RDCHK: begin
                n_cnt    = 2'd1;
                n_evalue = '0;
                n_erase  = 1'b0;
                n_ekind  = tlc_pkg::KIND_NONE;
                n_n      = '0;
                n_state  = tlc_pkg::S_EMIT;
                if (r_eof && (r_fill == '0)) begin
                    n_eof   = 1'b0;
                    n_ready = 1'b0;
                    n_ekind = tlc_pkg::KIND_EOF;
                end else if (!(r_ready || full || r_cfg.raw)) begin
                    n_ekind = tlc_pkg::KIND_NONE;
                end else if (r_fill == '0) begin
                    n_ready = 1'b0;
                end else if (r_len != '0) begin
                    n_state = tlc_pkg::S_RDADR;
                end
            end
            tlc_pkg::S_RDADR: begin
                ram_re  = 1'b1;
                n_state = tlc_pkg::S_RDDAT;
            end
            tlc_pkg::S_RDDAT: begin
                if (slot_free) begin
                    emit_valid = 1'b1;
                    emit_kind  = tlc_pkg::KIND_DATA;
                    emit_value = ram_rdata;
                    emit_last  = rd_last;
                    n_head     = (r_head == tlc_pkg::PTR_W'(tlc_pkg::LINE_DEPTH - 1)) ?
                                 '0 : r_head + 1'b1;
                    n_fill     = r_fill - 1'b1;
                    n_n        = r_n + 1'b1;
                    if (rd_last) begin
                        if (r_fill == tlc_pkg::CNT_W'(1)) begin
                            n_ready = 1'b0;
                        end
                        n_state = tlc_pkg::S_IDLE;
                    end else begin
                        n_state = tlc_pkg::S_RDADR;
                    end
                end
            end
            tlc_pkg::S_EMIT: begin
                if (slot_free) begin
                    emit_valid = 1'b1;
                    emit_kind  = r_ekind;
                    emit_last  = (r_cnt == 2'd1);
                    if (r_erase) begin
                        emit_value = (r_cnt == 2'd2) ? tlc_pkg::CH_SPACE : tlc_pkg::CH_BS;
                    end else begin
                        emit_value = r_evalue;
                    end
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == 2'd1) begin
                        n_state = tlc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = tlc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlc_pkg::S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_ready     <= 1'b0;
            r_eof       <= 1'b0;
            r_n         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= '{raw: 1'b0, echo: 1'b1, n2r: 1'b0, ign: 1'b0, r2n: 1'b1};
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_ready <= n_ready;
            r_eof   <= n_eof;
            r_n     <= n_n;
            r_cnt   <= n_cnt;
            if (slot_free) begin
                r_out_valid <= emit_valid;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tlc_pkg::CFG_RAW:  r_cfg.raw  <= i_cfg_data;
                    tlc_pkg::CFG_ECHO: r_cfg.echo <= i_cfg_data;
                    tlc_pkg::CFG_N2R:  r_cfg.n2r  <= i_cfg_data;
                    tlc_pkg::CFG_IGN:  r_cfg.ign  <= i_cfg_data;
                    tlc_pkg::CFG_R2N:  r_cfg.r2n  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ekind  <= n_ekind;
        r_evalue <= n_evalue;
        r_erase  <= n_erase;
        if (in_xfer) begin
            r_char <= i_char_in;
            r_len  <= len_clamped;
        end
        if (emit_valid) begin
            r_kind  <= emit_kind;
            r_value <= emit_value;
            r_last  <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

// File: rtl/tlc_check.sv
// Port checker for the terminal line cooker, with its bind.
module tlc_check (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      i_op,
    input logic [7:0]                i_char_in,
    input logic [tlc_pkg::LEN_W-1:0] i_read_len,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [2:0]                o_kind,
    input logic [7:0]                o_value,
    input logic                      o_last
);

    // stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_kind) &&
                                          $stable(o_value) && $stable(o_last)))
        else $error("output payload changed while stalled");

    // one item at a time: an input transfer closes the input side
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // single-result kinds always end their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == tlc_pkg::KIND_EOF || o_kind == tlc_pkg::KIND_NONE ||
                         o_kind == tlc_pkg::KIND_REFUSED)) |-> o_last)
        else $error("single-result kind without last");

    // end of file and nothing-ready carry a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == tlc_pkg::KIND_EOF || o_kind == tlc_pkg::KIND_NONE))
        |-> (o_value == 8'h00))
        else $error("non-zero value on status result");

endmodule

bind terminal_line_cooker tlc_check u_tlc_check (.*);

// File: dv/tb.sv
// Testbench for terminal_line_cooker: directed table, then random line traffic under several modes.
`timescale 1ns / 100ps

module tb;
    import tlc_pkg::*;

    localparam int LIMIT = 600000;
    localparam int PER_PHASE = 41;
    // raw, echo, nl->cr, ignore cr, cr->nl
    localparam logic [4:0] MODES [6] = '{5'b01001, 5'b01100, 5'b00010,
                                         5'b10000, 5'b11111, 5'b01111};

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } t_res;

    typedef struct {
        logic                op;
        logic [7:0]          ch;
        logic [LEN_W-1:0]    len;
    } t_item;

    typedef struct {
        t_item it;
        bit    typed;
        t_res  want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_op = 1'b0;
    logic [7:0]          i_char_in = '0;
    logic [LEN_W-1:0]    i_read_len = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [2:0]          o_kind;
    logic [7:0]          o_value;
    logic                o_last;
    logic                i_cfg_we = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index = '0;
    logic                i_cfg_data = 1'b0;

    terminal_line_cooker i_dut (.*);

    // line discipline model state
    logic [7:0]       line_mem [LINE_DEPTH];
    logic [PTR_W-1:0] rd_ptr = '0;
    int               fill = 0;
    bit               ready = 1'b0;
    bit               eof_flag = 1'b0;
    t_cfg             mode = 5'b01001;

    t_res  cooked_res[$];
    t_res  due_results[$];
    t_row  dir_rows[$];
    t_item script[$];

    int         errs = 0;
    int         cycles = 0;
    int         burst_left = 0;
    logic [7:0] stall_age = '0;
    int         stall_style = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver back-pressure, style changes each time the 8-bit stall_age counter wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_age <= stall_age + 8'd1;
            if (stall_age == 8'd0) begin
                stall_style <= $urandom_range(0, 3);
            end
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= (stall_age[2:0] < 3'd3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d value %02h last %0b",
                       o_kind, o_value, o_last);
                errs++;
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    errs++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %02h, got %02h", want.value, o_value);
                    errs++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    errs++;
                end
            end
        end
    end

    function automatic void put(logic [2:0] k, logic [7:0] v);
        t_res r;
        r.kind = k;
        r.value = v;
        r.last = 1'b0;
        cooked_res.push_back(r);
    endfunction

    function automatic void put_echo(logic [7:0] c);
        if (c == CH_BS || c == CH_DEL) begin
            put(KIND_ECHO, CH_BS);
            put(KIND_ECHO, CH_SPACE);
            put(KIND_ECHO, CH_BS);
        end else begin
            put(KIND_ECHO, c);
        end
    endfunction

    function automatic void store(logic [7:0] c);
        logic [PTR_W-1:0] w;
        w = rd_ptr + fill[PTR_W-1:0];
        line_mem[w] = c;
        fill++;
    endfunction

    // results of one transfer into cooked_res, line state updated
    function automatic void cook_item(t_item it);
        int         lim;
        logic [7:0] c;
        bit         keep;
        cooked_res.delete();
        if (!it.op) begin
            c = it.ch;
            keep = 1'b1;
            if (ready || fill >= LINE_DEPTH) begin
                put(KIND_REFUSED, c);
                keep = 1'b0;
            end else if (mode.raw) begin
                store(c);
                put_echo(c);
                keep = 1'b0;
            end else if (c == CH_BS || c == CH_DEL) begin
                if (fill == 0) keep = 1'b0;
                else fill--;
            end else if (c == CH_NL) begin
                if (mode.n2r) c = CH_CR;
                store(c);
                ready = 1'b1;
            end else if (c == CH_CR) begin
                if (mode.ign) begin
                    keep = 1'b0;
                end else begin
                    if (mode.r2n) c = CH_NL;
                    store(c);
                    ready = 1'b1;
                end
            end else if (c == CH_EOT) begin
                eof_flag = 1'b1;
                ready = 1'b1;
            end else if (c < CH_SPACE || c > CH_TILDE) begin
                keep = 1'b0;
            end else begin
                store(c);
            end
            if (keep && mode.echo) put_echo(c);
        end else begin
            lim = (it.len > MAX_READ) ? MAX_READ : int'(it.len);
            if (eof_flag && fill == 0) begin
                eof_flag = 1'b0;
                ready = 1'b0;
                put(KIND_EOF, 8'h00);
            end else if (!(ready || fill >= LINE_DEPTH || mode.raw)) begin
                put(KIND_NONE, 8'h00);
            end else begin
                while (fill > 0 && cooked_res.size() < lim) begin
                    put(KIND_DATA, line_mem[rd_ptr]);
                    fill--;
                    rd_ptr++;
                end
                if (fill == 0) ready = 1'b0;
                if (cooked_res.size() == 0) put(KIND_NONE, 8'h00);
            end
        end
        if (cooked_res.size() > 0) cooked_res[cooked_res.size() - 1].last = 1'b1;
    endfunction

    task automatic send(input t_item it, input bit typed, input t_res want, output int n);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= it.op;
        i_char_in <= it.ch;
        i_read_len <= it.len;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        cook_item(it);
        n = cooked_res.size();
        if (typed) due_results.push_back(want);
        else foreach (cooked_res[i]) due_results.push_back(cooked_res[i]);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_cfg m);
        logic [IDX_W-1:0] idx [5];
        logic             bits [5];
        idx = '{CFG_RAW, CFG_ECHO, CFG_N2R, CFG_IGN, CFG_R2N};
        bits = '{m.raw, m.echo, m.n2r, m.ign, m.r2n};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= bits[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        mode = m;
    endtask

    task automatic add_row(input logic op, input logic [7:0] ch, input logic [LEN_W-1:0] len,
                           input bit typed, input logic [2:0] kind, input logic [7:0] value);
        t_row r;
        r.it.op = op;
        r.it.ch = ch;
        r.it.len = len;
        r.typed = typed;
        r.want.kind = kind;
        r.want.value = value;
        r.want.last = 1'b1;
        dir_rows.push_back(r);
    endtask

    initial begin
        t_res  none_res;
        t_item it;
        int    n;
        int    counted;
        int    k;
        none_res = '0;

        add_row(1'b1, 8'h00,  6'd5, 1, KIND_NONE,    8'h00);
        add_row(1'b0, CH_DEL, 6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, CH_BS,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, 8'h00,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, 8'h20,  6'd0, 1, KIND_ECHO,    8'h20);
        add_row(1'b0, 8'h7E,  6'd0, 1, KIND_ECHO,    8'h7E);
        add_row(1'b0, 8'h1F,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, 8'hFF,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, 8'h80,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, 8'h41,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, CH_BS,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, CH_CR,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, 8'h42,  6'd0, 1, KIND_REFUSED, 8'h42);
        add_row(1'b1, 8'h00,  6'd0, 1, KIND_NONE,    8'h00);
        add_row(1'b1, 8'h00, 6'd63, 0, KIND_NONE,    8'h00);
        add_row(1'b1, 8'h00,  6'd1, 1, KIND_NONE,    8'h00);
        add_row(1'b0, CH_EOT, 6'd0, 1, KIND_ECHO,    CH_EOT);
        add_row(1'b1, 8'h00, 6'd32, 1, KIND_EOF,     8'h00);
        add_row(1'b0, 8'h61,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b0, CH_EOT, 6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b1, 8'h00,  6'd1, 0, KIND_NONE,    8'h00);
        add_row(1'b1, 8'h00,  6'd1, 1, KIND_EOF,     8'h00);
        add_row(1'b0, CH_NL,  6'd0, 0, KIND_NONE,    8'h00);
        add_row(1'b1, 8'h00,  6'd2, 0, KIND_NONE,    8'h00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want, n);
        drain();

        for (int p = 0; p < 7; p++) begin
            set_mode((p < 6) ? t_cfg'(MODES[p]) : t_cfg'($urandom_range(0, 31)));
            counted = 0;
            while (counted < PER_PHASE) begin
                script.delete();
                if ($urandom_range(0, 6) != 0) begin
                    // a typed line, its terminator, then reads to drain it
                    k = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36)
                                                    : $urandom_range(0, 10);
                    it.op = 1'b0;
                    it.len = LEN_W'($urandom_range(0, 63));
                    for (int i = 0; i < k; i++) begin
                        if ($urandom_range(0, 9) == 0)
                            it.ch = $urandom_range(0, 1) ? CH_BS : CH_DEL;
                        else if ($urandom_range(0, 19) == 0)
                            it.ch = 8'($urandom_range(0, 255));
                        else
                            it.ch = 8'($urandom_range(8'h20, 8'h7E));
                        script.push_back(it);
                    end
                    case ($urandom_range(0, 3))
                        0: it.ch = CH_NL;
                        1: it.ch = CH_EOT;
                        default: it.ch = CH_CR;
                    endcase
                    script.push_back(it);
                    it.op = 1'b1;
                    k = $urandom_range(1, 4);
                    for (int i = 0; i < k; i++) begin
                        it.ch = 8'($urandom_range(0, 255));
                        case ($urandom_range(0, 9))
                            0: it.len = '0;
                            1: it.len = LEN_W'($urandom_range(33, 63));
                            default: it.len = LEN_W'($urandom_range(1, 12));
                        endcase
                        script.push_back(it);
                    end
                end else begin
                    k = $urandom_range(1, 4);
                    for (int i = 0; i < k; i++) begin
                        it.op = 1'($urandom_range(0, 1));
                        it.ch = 8'($urandom_range(0, 255));
                        it.len = LEN_W'($urandom_range(0, 63));
                        script.push_back(it);
                    end
                end
                foreach (script[i]) begin
                    if (counted < PER_PHASE) begin
                        send(script[i], 1'b0, none_res, n);
                        counted++;
                    end
                end
            end
            drain();
        end

        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
